[rtl/ripemd160_hash_top_defines.svh]
// assertion macros for the ripemd160 hasher
`ifndef RIPEMD160_HASH_TOP_DEFINES_SVH
`define RIPEMD160_HASH_TOP_DEFINES_SVH

// assert that a condition implies another on the same edge
`define RMD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// assert that a condition implies another on the next edge
`define RMD_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

[rtl/rmd160_pkg.sv]
// package: types, constants and round tables for the ripemd160 hasher
`timescale 1ns / 1ps
package rmd160_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

  localparam logic [31:0] INIT_WORD [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};

  function automatic logic [3:0] left_sel(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,
      4'd14,4'd15,
      4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
      4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
      4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
      4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
    return t[j];
  endfunction

  function automatic logic [3:0] right_sel(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,
      4'd12,
      4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
      4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
      4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
      4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
    return t[j];
  endfunction

  function automatic logic [3:0] left_rot(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,
      4'd9,4'd8,
      4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
      4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
      4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
      4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};
    return t[j];
  endfunction

  function automatic logic [3:0] right_rot(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,
      4'd12,4'd6,
      4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
      4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
      4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
      4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};
    return t[j];
  endfunction

  function automatic logic [31:0] left_k(input logic [2:0] g);
    case (g)
      3'd0: return 32'h00000000;
      3'd1: return 32'h5a827999;
      3'd2: return 32'h6ed9eba1;
      3'd3: return 32'h8f1bbcdc;
      default: return 32'ha953fd4e;
    endcase
  endfunction

  function automatic logic [31:0] right_k(input logic [2:0] g);
    case (g)
      3'd0: return 32'h50a28be6;
      3'd1: return 32'h5c4dd124;
      3'd2: return 32'h6d703ef3;
      3'd3: return 32'h7a6d76e9;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [31:0] boolfn(input logic [2:0] f, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    case (f)
      3'd0: return x ^ y ^ z;
      3'd1: return (x & y) | (~x & z);
      3'd2: return (x | ~y) ^ z;
      3'd3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

[rtl/rmd160_ram.sv]
// generic single-port write, single-port read ram with registered read
`timescale 1ns / 1ps
module rmd160_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/rmd160_core.sv]
// compression core: 80 two-line rounds reading message words from the block ram
`timescale 1ns / 1ps
module rmd160_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmd160_pkg::core_ctl_t  ctl_in,
  output logic [3:0]             raddr,
  input  logic [31:0]            rdata,
  output logic                   done,
  output logic [31:0]            cv0,
  output logic [31:0]            cv1,
  output logic [31:0]            cv2,
  output logic [31:0]            cv3,
  output logic [31:0]            cv4,
  input  logic                   cv_reset
);
  import rmd160_pkg::*;

  // phase: 0 issues left read, 1 captures left word and issues right read, 2 computes both lines
  logic [6:0]  rnd_r, rnd_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        run_r, run_nxt;
  logic [31:0] cv_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] ar_r, br_r, cr_r, dr_r, er_r;
  logic [31:0] wl_r;
  logic [2:0]  g;
  logic [31:0] tl, tr;

  assign g = 3'(rnd_r[6:4]);

  always_comb begin
    tl = rotl(a_r + boolfn(g, b_r, c_r, d_r) + wl_r + left_k(g), left_rot(rnd_r)) + e_r;
    tr = rotl(ar_r + boolfn(3'd4 - g, br_r, cr_r, dr_r) + rdata + right_k(g),
              right_rot(rnd_r)) + er_r;
  end

  always_comb begin
    raddr = (ph_r == 2'd0) ? left_sel(rnd_r) : right_sel(rnd_r);
    run_nxt = run_r;
    rnd_nxt = rnd_r;
    ph_nxt = ph_r;
    done = 1'b0;
    if (!run_r) begin
      if (ctl_in.start) begin
        run_nxt = 1'b1;
        rnd_nxt = '0;
        ph_nxt = 2'd0;
      end
    end else begin
      case (ph_r)
        2'd0: ph_nxt = 2'd1;
        2'd1: ph_nxt = 2'd2;
        default: begin
          ph_nxt = 2'd0;
          if (rnd_r == 7'd79) begin
            run_nxt = 1'b0;
            done = 1'b1;
          end else begin
            rnd_nxt = rnd_r + 7'd1;
          end
        end
      endcase
    end
  end

  // fold uses the line values as they stand after the final round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      rnd_r <= '0;
      ph_r <= '0;
      for (int i = 0; i < 5; i++) cv_r[i] <= INIT_WORD[i];
    end else begin
      run_r <= run_nxt;
      rnd_r <= rnd_nxt;
      ph_r <= ph_nxt;
      if (cv_reset) begin
        for (int i = 0; i < 5; i++) cv_r[i] <= INIT_WORD[i];
      end else if (done) begin
        cv_r[0] <= cv_r[1] + b_r + rotl(cr_r, 4'd10);
        cv_r[1] <= cv_r[2] + rotl(c_r, 4'd10) + dr_r;
        cv_r[2] <= cv_r[3] + d_r + er_r;
        cv_r[3] <= cv_r[4] + e_r + tr;
        cv_r[4] <= cv_r[0] + tl + br_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!run_r && ctl_in.start) begin
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3]; e_r <= cv_r[4];
      ar_r <= cv_r[0]; br_r <= cv_r[1]; cr_r <= cv_r[2]; dr_r <= cv_r[3]; er_r <= cv_r[4];
    end else if (run_r) begin
      if (ph_r == 2'd1) begin
        wl_r <= rdata;
      end else if (ph_r == 2'd2) begin
        a_r <= e_r; e_r <= d_r; d_r <= rotl(c_r, 4'd10); c_r <= b_r; b_r <= tl;
        ar_r <= er_r; er_r <= dr_r; dr_r <= {cr_r[21:0], cr_r[31:22]}; cr_r <= br_r;
        br_r <= tr;
      end
    end
  end

  assign cv0 = cv_r[0];
  assign cv1 = cv_r[1];
  assign cv2 = cv_r[2];
  assign cv3 = cv_r[3];
  assign cv4 = cv_r[4];
endmodule

[rtl/ripemd160_hash_top.sv]
// Streaming RIPEMD-160 hasher. One transaction moves one message byte and/or an
// end-of-message mark; an accepted byte is stored in a 16-word block memory. A full
// block runs 80 rounds; each round reads its left and right message words in turn
// through the single read port of the block memory, so the byte that completes a
// block holds the input off while the block passes through the load, round and fold
// states. End of message writes padding one byte per cycle up to the end of the
// block and runs one or two padding blocks, then emits five digest words as five
// output transactions.
`timescale 1ns / 1ps
module ripemd160_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // data_byte
  input  logic [1:0]  in_tuser,  // byte_present, end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // digest_word, word_index, zero fill
  output logic        out_tlast  // last_word
);
  import rmd160_pkg::*;
  `include "ripemd160_hash_top_defines.svh"

  state_t      st_r, st_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        eom_r, eom_nxt;
  logic        two_r, two_nxt;
  logic        pad_r, pad_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [31:0] wbuf_r, wbuf_nxt;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata, rdata;
  logic [3:0]  raddr;
  logic        done, cv_reset;
  core_ctl_t   ctl;
  logic [31:0] cv [5];
  logic [63:0] bits;
  logic        acc, oacc;

  assign acc = in_tvalid && in_tready;
  assign oacc = out_tvalid && out_tready;
  assign bits = {cnt_r, 3'b000};

  rmd160_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  rmd160_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl), .raddr(raddr), .rdata(rdata), .done(done),
    .cv0(cv[0]), .cv1(cv[1]), .cv2(cv[2]), .cv3(cv[3]), .cv4(cv[4]), .cv_reset(cv_reset));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_tuser[0] && pos_r == 6'd63) st_nxt = ST_LOAD;
          else if (in_tuser[1]) st_nxt = ST_PAD;
        end
      end
      ST_LOAD: st_nxt = ST_ROUND;
      ST_ROUND: if (done) st_nxt = ST_FOLD;
      ST_FOLD: begin
        if (eom_r && pad_r && !two_r) st_nxt = ST_OUT;
        else if (eom_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_PAD: if (pos_r == 6'd63) st_nxt = ST_LOAD;
      ST_OUT: if (oacc && oidx_r == 3'd4) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // byte writes go through a word buffer; a word is written when its top byte lands
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    ctl.start = (st_r == ST_LOAD);
    ctl.busy = (st_r == ST_ROUND);
    cv_reset = 1'b0;
    out_tvalid = (st_r == ST_OUT);
    out_tdata = {5'd0, oidx_r, cv[oidx_r]};
    out_tlast = (oidx_r == 3'd4);
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    eom_nxt = eom_r;
    two_nxt = two_r;
    pad_nxt = pad_r;
    oidx_nxt = oidx_r;
    wbuf_nxt = wbuf_r;
    we = 1'b0;
    waddr = pos_r[5:2];
    wdata = wbuf_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_tuser[0]) begin
            wbuf_nxt[8*pos_r[1:0] +: 8] = in_tdata;
            wdata = wbuf_nxt;
            we = (pos_r[1:0] == 2'd3);
            pos_nxt = pos_r + 6'd1;
            cnt_nxt = cnt_r + 61'd1;
          end
          if (in_tuser[1]) begin
            eom_nxt = 1'b1;
            two_nxt = 1'b0;
          end
        end
      end
      ST_FOLD: begin
        if (eom_r && pad_r && !two_r) oidx_nxt = 3'd0;
      end
      ST_PAD: begin
        // pad byte once, then zeros, then length in the last padding block, one byte per cycle
        if (!pad_r) begin
          wbuf_nxt[8*pos_r[1:0] +: 8] = 8'h80;
          pad_nxt = 1'b1;
        end else if (pos_r >= 6'd56 && (two_r || cnt_r[5:0] < 6'd56)) begin
          wbuf_nxt[8*pos_r[1:0] +: 8] = bits[8*pos_r[2:0] +: 8];
        end else begin
          wbuf_nxt[8*pos_r[1:0] +: 8] = 8'h00;
        end
        wdata = wbuf_nxt;
        we = (pos_r[1:0] == 2'd3);
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          // a second padding block follows when the length does not fit
          two_nxt = !two_r && (cnt_r[5:0] >= 6'd56);
        end
      end
      ST_OUT: begin
        if (oacc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd4) begin
            oidx_nxt = '0;
            cv_reset = 1'b1;
            cnt_nxt = '0;
            pos_nxt = '0;
            eom_nxt = 1'b0;
            two_nxt = 1'b0;
            pad_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      pos_r <= '0;
      eom_r <= 1'b0;
      two_r <= 1'b0;
      pad_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      eom_r <= eom_nxt;
      two_r <= two_nxt;
      pad_r <= pad_nxt;
      oidx_r <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
  end

  `RMD_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, st_r == ST_IDLE && !out_tvalid)
  `RMD_ASSERT_IMP(a_idx_range, clk, rst_n, out_tvalid, oidx_r <= 3'd4)
  `RMD_ASSERT_NXT(a_last_clear, clk, rst_n, oacc && out_tlast, cnt_r == 61'd0)
endmodule
